// ===== hdl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal ascii converter.
// No dependencies; used by every module under hdl.
package sitda_pkg;

  // ascii character width and codes
  localparam int CHAR_BITS = 7;
  localparam int DIGIT_BITS = 4;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE = 7'd57;

  // handoff from the bcd converter to the character emitter
  typedef struct packed {
    logic valid;
    logic negative;
  } handoff_t;

endpackage

// ===== hdl/sitda_bcd.sv =====
// Bit-serial binary to bcd converter (shift and add three), one bit per cycle.
// Depends on sitda_pkg for the handoff struct and digit width.
module sitda_bcd #(
  parameter int VALUE_BITS = 32,
  parameter int NUM_DIGITS = 10
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic [VALUE_BITS-1:0]                     value,
  output logic                                      running,
  output sitda_pkg::handoff_t                       hand,
  output logic [NUM_DIGITS*sitda_pkg::DIGIT_BITS-1:0] bcd
);

  localparam int BCD_W = NUM_DIGITS * sitda_pkg::DIGIT_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_in;
  logic [CNT_W-1:0]      cnt;
  logic [BCD_W-1:0]      adjusted;

  // magnitude of the request, most negative value stays 2^(n-1) unsigned
  assign mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] >= 4'd5) begin
        adjusted[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] =
          bcd[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] + 4'd3;
      end else begin
        adjusted[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] =
          bcd[i*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS];
      end
    end
  end

  // control: load, count shifts, pulse the handoff at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      hand <= '0;
      cnt <= '0;
    end else begin
      if (load) begin
        running <= 1'b1;
        cnt <= CNT_W'(VALUE_BITS);
        hand.valid <= 1'b0;
        hand.negative <= value[VALUE_BITS-1];
      end else if (running) begin
        cnt <= cnt - 1'b1;
        running <= (cnt != CNT_W'(1));
        hand.valid <= (cnt == CNT_W'(1));
      end else begin
        hand.valid <= 1'b0;
      end
    end
  end

  // datapath: shift magnitude msb first into the bcd register
  always_ff @(posedge clk) begin
    if (load) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (running) begin
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd <= {adjusted[BCD_W-2:0], mag[VALUE_BITS-1]};
    end
  end

endmodule

// ===== hdl/sitda_emit.sv =====
// Character emitter: walks the bcd digits msb first, skips leading zeros.
// Depends on sitda_pkg for character codes and the handoff struct.
module sitda_emit #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  sitda_pkg::handoff_t                         hand,
  input  logic [NUM_DIGITS*sitda_pkg::DIGIT_BITS-1:0] bcd,
  output logic                                        active,
  output logic                                        char_valid,
  output logic [sitda_pkg::CHAR_BITS-1:0]             char_code,
  output logic                                        last_char
);

  localparam int BCD_W = NUM_DIGITS * sitda_pkg::DIGIT_BITS;
  localparam int LEFT_W = $clog2(NUM_DIGITS + 1);

  logic [BCD_W-1:0]                  digits;
  logic [LEFT_W-1:0]                 dig_left;
  logic                              neg_pend;
  logic                              started;
  logic [sitda_pkg::DIGIT_BITS-1:0]  top;
  logic                              final_digit;

  assign top = digits[BCD_W-1 -: sitda_pkg::DIGIT_BITS];
  assign final_digit = (dig_left == LEFT_W'(1));

  // a character leaves for the sign, for any digit past the leading zeros, or for the final digit
  assign char_valid = active & (neg_pend | started | (top != '0) | final_digit);
  assign char_code = neg_pend ? sitda_pkg::CHAR_MINUS
                              : sitda_pkg::CHAR_ZERO + {3'b000, top};
  assign last_char = char_valid & ~neg_pend & final_digit;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      neg_pend <= 1'b0;
      started <= 1'b0;
      dig_left <= '0;
    end else if (hand.valid) begin
      active <= 1'b1;
      neg_pend <= hand.negative;
      started <= 1'b0;
      dig_left <= LEFT_W'(NUM_DIGITS);
    end else if (active) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        dig_left <= dig_left - 1'b1;
        if (top != '0) begin
          started <= 1'b1;
        end
        if (final_digit) begin
          active <= 1'b0;
        end
      end
    end
  end

  // digit shift register, one digit per cycle once the sign has left
  always_ff @(posedge clk) begin
    if (hand.valid) begin
      digits <= bcd;
    end else if (active && !neg_pend) begin
      digits <= digits << sitda_pkg::DIGIT_BITS;
    end
  end

endmodule

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ascii converter.
// Depends on sitda_pkg, sitda_bcd and sitda_emit.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   value is sampled there. The block then emits the decimal text of value,
//   one ascii character per char_valid cycle, most significant first: '-'
//   for a negative value, then the digits without leading zeros (zero gives
//   a single '0'). last_char marks the final character. Each character is on
//   char_code for exactly one cycle; the receiver cannot stall it.
// Timing:
//   The bcd converter shifts the magnitude in one bit per cycle; the emitter
//   then walks the NUM_DIGITS digit register one digit per cycle, after the
//   sign when the value is negative. busy stays high from the request until
//   the last character. The sign, or the leading digit slot, is on char_code
//   once the bcd converter hands off; each skipped leading zero delays the
//   first digit.
// Reset:
//   rst (synchronous) drops busy and abandons any conversion in flight.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [VALUE_BITS-1:0]        value,
  output logic                                char_valid,
  output logic [sitda_pkg::CHAR_BITS-1:0]     char_code,
  output logic                                last_char
);

  // decimal digits of 2^(VALUE_BITS-1): floor((n-1)*log10(2)) + 1
  localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
  localparam int BCD_W = NUM_DIGITS * sitda_pkg::DIGIT_BITS;

  logic                conv_running;
  logic                emit_active;
  logic                load;
  sitda_pkg::handoff_t hand;
  logic [BCD_W-1:0]    bcd;

  assign busy = conv_running | hand.valid | emit_active;
  assign load = start & ~busy;

  // bit-serial binary to bcd
  sitda_bcd #(
    .VALUE_BITS(VALUE_BITS),
    .NUM_DIGITS(NUM_DIGITS)
  ) u_bcd (
    .clk(clk),
    .rst(rst),
    .load(load),
    .value($unsigned(value)),
    .running(conv_running),
    .hand(hand),
    .bcd(bcd)
  );

  // digit-serial character output
  sitda_emit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .hand(hand),
    .bcd(bcd),
    .active(emit_active),
    .char_valid(char_valid),
    .char_code(char_code),
    .last_char(last_char)
  );

  // a character only leaves while a request is in flight
  a_char_in_request: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> busy)
    else $error("character emitted while idle");

  // a taken request keeps the block busy
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> busy)
    else $error("busy not raised after request");

  // the final character ends the run
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |=> !char_valid)
    else $error("character emitted after last character");

  // only the sign or a decimal digit is emitted
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code == sitda_pkg::CHAR_MINUS) ||
      ((char_code >= sitda_pkg::CHAR_ZERO) && (char_code <= sitda_pkg::CHAR_NINE)))
    else $error("character code out of range");

endmodule

// ===== dv/tb_signed_int_to_decimal_ascii.sv =====
// Self-checking testbench for the signed integer to decimal ascii converter.
// Depends on sitda_pkg and signed_int_to_decimal_ascii under hdl; stands alone.
module tb_signed_int_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 32;
  localparam int RADIX = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM = 140;

  // one character of decimal text as the block should emit it
  typedef struct packed {
    logic [sitda_pkg::CHAR_BITS-1:0] code;
    logic                            is_last;
  } ascii_char_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  logic signed [VALUE_BITS-1:0]        value = '0;
  logic                                char_valid;
  logic [sitda_pkg::CHAR_BITS-1:0]     char_code;
  logic                                last_char;

  ascii_char_t pending_chars[$];
  ascii_char_t want;
  int          mismatches = 0;
  int          burst_left = 0;

  // directed values; a non-empty text is the expected output read off directly
  logic signed [VALUE_BITS-1:0] directed_values [NUM_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99, 32'sd100,
    32'sh7fff_ffff, -32'sd2147483647, 32'sh8000_0000, 32'sd1000000000,
    32'sd999999999, -32'sd1000000000, 32'sd1234567890, -32'sd987654321,
    32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7
  };
  string directed_texts [NUM_DIRECTED] = '{
    "0", "1", "-1", "9", "10", "", "", "", "",
    "2147483647", "-2147483647", "-2147483648", "1000000000",
    "", "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .char_valid(char_valid),
    .char_code (char_code),
    .last_char (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // decimal text of a two's complement value, most significant character first
  function automatic void append_decimal_text(input logic signed [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0]            magnitude;
    logic [sitda_pkg::DIGIT_BITS-1:0] digits[$];
    logic                             negative;
    ascii_char_t                      ch;
    negative = v[VALUE_BITS-1];
    // most negative value wraps back onto itself, read as unsigned 2^(n-1)
    magnitude = negative ? (~v + 1'b1) : v;
    do begin
      digits.push_front(sitda_pkg::DIGIT_BITS'(magnitude % RADIX));
      magnitude = magnitude / RADIX;
    end while (magnitude != 0);
    if (negative) begin
      ch.code = sitda_pkg::CHAR_MINUS;
      ch.is_last = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int k = 0; k < digits.size(); k++) begin
      ch.code = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_BITS'(digits[k]);
      ch.is_last = (k == digits.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function automatic void append_typed_text(input string text);
    ascii_char_t ch;
    for (int k = 0; k < text.len(); k++) begin
      ch.code = sitda_pkg::CHAR_BITS'(text[k]);
      ch.is_last = (k == text.len() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // present one request, hold it until taken, then log what it should produce
  task automatic issue_request(input logic signed [VALUE_BITS-1:0] v, input string text);
    if (!start) start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (text.len() == 0) append_decimal_text(v);
    else append_typed_text(text);
  endtask

  // requests go out in bursts; a gap follows each burst, after a full drain at times
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v, input string text,
                            input bit force_drain);
    bit drain;
    issue_request(v, text);
    if (burst_left > 0 && !force_drain) begin
      burst_left--;
    end else begin
      drain = force_drain || ($urandom_range(0, 7) == 0);
      start <= 1'b0;
      while (drain && pending_chars.size() != 0) @(posedge clk);
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic signed [VALUE_BITS-1:0] v;
    logic signed [VALUE_BITS-1:0] power;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 999);
      6, 7: begin
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * RADIX;
        v = power - $urandom_range(0, 1);
      end
      8: v = $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                  : 32'sh8000_0000 + $urandom_range(0, 3);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) && v != 32'sh8000_0000) v = -v;
    return v;
  endfunction

  // compare every emitted character with the oldest expected one
  always @(posedge clk) begin
    if (!rst && char_valid) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("char %0d with nothing expected", char_code));
      end else begin
        want = pending_chars.pop_front();
        if (char_code !== want.code)
          flag_mismatch($sformatf("char_code %0d, expected %0d", char_code, want.code));
        if (last_char !== want.is_last)
          flag_mismatch($sformatf("last_char %b, expected %b", last_char, want.is_last));
      end
    end
  end

  // watchdog on cycles where neither a request nor a character is taken
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || char_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("signed_int_to_decimal_ascii regression: fail");
    $finish;
  end

  // stimulus: reset, directed table, random values, then drain
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_value(directed_values[i], directed_texts[i], i == NUM_DIRECTED - 1);
    for (int i = 0; i < NUM_RANDOM; i++)
      send_value(random_value(), "", i == NUM_RANDOM - 1);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_int_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
